### hdl/pattern_span_fill_unit_macros.svh
// ----------------------------------------------------------------------------
// Pattern span fill unit: assertion macros
// Shared concurrent assertion forms, clocked on aclk, muted during reset.
// ----------------------------------------------------------------------------
`ifndef PATTERN_SPAN_FILL_UNIT_MACROS_SVH
`define PATTERN_SPAN_FILL_UNIT_MACROS_SVH

// Same-cycle implication
`define PSF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define PSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pspf_pkg.sv
// ----------------------------------------------------------------------------
// Pattern span fill package
// Types, register indexes, codes and the pattern bit lookup.
// ----------------------------------------------------------------------------
package pspf_pkg;

    // Default and fixed sizes
    localparam int MAX_SPAN_DEF  = 64;
    localparam int PATTERN_SIZE  = 8;

    // Configuration register indexes
    localparam logic [2:0] REG_PATTERN_BITS = 3'd0;
    localparam logic [2:0] REG_FG_PIXEL     = 3'd1;
    localparam logic [2:0] REG_BG_PIXEL     = 3'd2;
    localparam logic [2:0] REG_ORIGIN       = 3'd3;
    localparam logic [2:0] REG_FILL_MODE    = 3'd4;
    localparam logic [2:0] REG_FRAME_BASE   = 3'd5;
    localparam logic [2:0] REG_ROW_STRIDE   = 3'd6;
    localparam logic [2:0] REG_CLIP_WINDOW  = 3'd7;

    // Nibble select codes
    localparam logic [1:0] NSEL_LO   = 2'd0;
    localparam logic [1:0] NSEL_HI   = 2'd1;
    localparam logic [1:0] NSEL_WORD = 2'd2;

    // Configuration register set
    typedef struct packed {
        logic [63:0] pattern_bits;
        logic [31:0] fg_pixel;
        logic [31:0] bg_pixel;
        logic [5:0]  pattern_origin;
        logic [1:0]  fill_mode;
        logic [31:0] frame_base;
        logic [15:0] row_stride;
        logic [63:0] clip_window;
    } cfg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_MUL,
        ST_BASE,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic load_span;
        logic do_clip;
        logic do_mul;
        logic do_base;
        logic emit_pix;
        logic emit_empty;
    } ctrl_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic empty;
        logic last_pix;
        logic slot_free;
    } stat_t;

    // Pattern bit for a pixel: row (y - oy) & 7, bit 7 - ((x - ox) & 7)
    function automatic logic pattern_hit(input logic [63:0] bits,
                                         input logic [5:0]  origin,
                                         input logic [2:0]  x3,
                                         input logic [2:0]  y3);
        logic [2:0] prow;
        logic [2:0] pcol;
        prow = y3 - origin[5:3];
        pcol = x3 - origin[2:0];
        return bits[{prow, ~pcol}];
    endfunction

endpackage

### hdl/pspf_seq.sv
// ----------------------------------------------------------------------------
// Pattern span fill sequencer
// Steps one span through clip, multiply, base add and per-pixel emission.
// ----------------------------------------------------------------------------
module pspf_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pspf_pkg::stat_t stat,
    output pspf_pkg::ctrl_t ctrl
);

    pspf_pkg::state_t state_reg;
    pspf_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pspf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pspf_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = pspf_pkg::ST_CLIP;
            end
            pspf_pkg::ST_CLIP: begin
                state_next = stat.empty ? pspf_pkg::ST_EMPTY : pspf_pkg::ST_MUL;
            end
            pspf_pkg::ST_MUL: begin
                state_next = pspf_pkg::ST_BASE;
            end
            pspf_pkg::ST_BASE: begin
                state_next = pspf_pkg::ST_EMIT;
            end
            pspf_pkg::ST_EMIT: begin
                if (stat.slot_free && stat.last_pix) state_next = pspf_pkg::ST_IDLE;
            end
            pspf_pkg::ST_EMPTY: begin
                if (stat.slot_free) state_next = pspf_pkg::ST_IDLE;
            end
            default: begin
                state_next = pspf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready = 1'b0;
        ctrl     = '0;
        unique case (state_reg)
            pspf_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                ctrl.load_span = s_tvalid;
            end
            pspf_pkg::ST_CLIP:  ctrl.do_clip    = 1'b1;
            pspf_pkg::ST_MUL:   ctrl.do_mul     = 1'b1;
            pspf_pkg::ST_BASE:  ctrl.do_base    = 1'b1;
            pspf_pkg::ST_EMIT:  ctrl.emit_pix   = stat.slot_free;
            pspf_pkg::ST_EMPTY: ctrl.emit_empty = stat.slot_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/pspf_dp.sv
// ----------------------------------------------------------------------------
// Pattern span fill datapath
// Span registers, clip logic, row multiply, one shared 32-bit address adder,
// pattern lookup and the output register.
// ----------------------------------------------------------------------------
module pspf_dp #(
    parameter int MAX_SPAN = pspf_pkg::MAX_SPAN_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  pspf_pkg::cfg_t  cfg,
    input  logic [15:0]     span_row,
    input  logic [15:0]     span_x_start,
    input  logic [15:0]     span_x_end,
    input  pspf_pkg::ctrl_t ctrl,
    output pspf_pkg::stat_t stat,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic            write_enable,
    output logic [31:0]     write_addr,
    output logic [31:0]     write_data,
    output logic [1:0]      nibble_select,
    output logic            last_write
);

    localparam int CNT_W = $clog2(MAX_SPAN + 1);

    logic [15:0]      row_reg, xs_reg, xe_reg, x_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [31:0]      prod_reg, row_addr_reg;
    logic             ov_reg, oen_reg, olast_reg;
    logic [31:0]      oaddr_reg, odata_reg;
    logic [1:0]       onsel_reg;

    logic [15:0]      cx0, cy0, cx1, cy1, lo, hi, len;
    logic             empty_c;
    logic [CNT_W-1:0] cnt_c;
    logic             stencil, wide, hit, en;
    logic [31:0]      pix, pix_off, add_a, add_b, sum;
    logic [31:0]      data_c;
    logic [1:0]       nsel_c;

    // Clip window fields and the clipped range
    assign cx0 = cfg.clip_window[15:0];
    assign cy0 = cfg.clip_window[31:16];
    assign cx1 = cfg.clip_window[47:32];
    assign cy1 = cfg.clip_window[63:48];
    assign lo  = (xs_reg > cx0) ? xs_reg : cx0;
    assign hi  = (xe_reg < cx1) ? xe_reg : cx1;
    assign len = hi - lo;
    assign empty_c = (row_reg < cy0) || (row_reg >= cy1) || (lo >= hi);
    assign cnt_c = (len > 16'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : CNT_W'(len);

    // Pixel attributes
    assign stencil = cfg.fill_mode[0];
    assign wide    = cfg.fill_mode[1];
    assign hit     = pspf_pkg::pattern_hit(cfg.pattern_bits, cfg.pattern_origin,
                                           x_reg[2:0], row_reg[2:0]);
    assign en      = !stencil || hit;
    assign pix     = hit ? cfg.fg_pixel : cfg.bg_pixel;
    assign pix_off = wide ? {14'd0, x_reg, 2'b00} : {17'd0, x_reg[15:1]};
    assign data_c  = !en ? 32'd0 : (wide ? pix : {28'd0, pix[3:0]});
    assign nsel_c  = wide ? pspf_pkg::NSEL_WORD
                          : (x_reg[0] ? pspf_pkg::NSEL_HI : pspf_pkg::NSEL_LO);

    // Shared adder: row base during the base step, pixel address after
    assign add_a = ctrl.do_base ? cfg.frame_base : row_addr_reg;
    assign add_b = ctrl.do_base ? prod_reg : pix_off;
    assign sum   = add_a + add_b;

    // Status to the sequencer; the clip decision is taken during the clip step
    assign stat.empty     = empty_c;
    assign stat.last_pix  = (rem_reg == CNT_W'(1));
    assign stat.slot_free = !ov_reg || m_tready;

    // Span working registers
    always_ff @(posedge aclk) begin
        if (ctrl.load_span) begin
            row_reg <= span_row;
            xs_reg  <= span_x_start;
            xe_reg  <= span_x_end;
        end
        if (ctrl.do_clip) begin
            x_reg   <= lo;
            rem_reg <= cnt_c;
        end
        if (ctrl.do_mul) begin
            prod_reg <= {16'd0, row_reg} * {16'd0, cfg.row_stride};
        end
        if (ctrl.do_base) begin
            row_addr_reg <= sum;
        end
        if (ctrl.emit_pix) begin
            x_reg   <= x_reg + 16'd1;
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    // Output valid: load on emit, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (ctrl.emit_pix || ctrl.emit_empty) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (ctrl.emit_pix) begin
            oen_reg   <= en;
            oaddr_reg <= sum;
            odata_reg <= data_c;
            onsel_reg <= nsel_c;
            olast_reg <= stat.last_pix;
        end else if (ctrl.emit_empty) begin
            oen_reg   <= 1'b0;
            oaddr_reg <= 32'd0;
            odata_reg <= 32'd0;
            onsel_reg <= pspf_pkg::NSEL_LO;
            olast_reg <= 1'b1;
        end
    end

    assign m_tvalid      = ov_reg;
    assign write_enable  = oen_reg;
    assign write_addr    = oaddr_reg;
    assign write_data    = odata_reg;
    assign nibble_select = onsel_reg;
    assign last_write    = olast_reg;

endmodule

### hdl/pattern_span_fill_unit.sv
// ----------------------------------------------------------------------------
// Pattern span fill unit
// Clips scan-line spans and writes them pixel by pixel with an 8x8 pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one span per transfer (row, first x, exclusive end x).
//   Output stream m_*: one pixel write per transfer, byte address and data in
//   tdata, write enable and nibble select in tuser, tlast on the final write
//   of a span. An empty or fully clipped span gives one disabled write.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at the
//   clock edge; write only while no span is in flight.
// Sequence and throughput:
//   After the span transfer the unit steps through clip, row multiply, base
//   add and first address add before the first write of a span is presented.
//   Then one write per cycle through the shared address adder while m_tready
//   does not stall the output. At most MAX_SPAN pixels of a span are written;
//   the next span is taken only once the last write of a span has been issued. s_tready is high only between spans.
// Reset: aresetn clears the sequencer, the output valid and the
//   configuration registers.
// Stall: a low m_tready with a write pending freezes the output register
//   and holds the sequencer in its emit states; no write is lost or repeated.
// ----------------------------------------------------------------------------
module pattern_span_fill_unit #(
    parameter int MAX_SPAN = pspf_pkg::MAX_SPAN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // Span input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] span_row, [31:16] span_x_start,
                                   // [47:32] span_x_end
    // Pixel write output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] write_addr, [63:32] write_data
    output logic [2:0]  m_tuser,   // [0] write_enable, [2:1] nibble_select
    output logic        m_tlast    // last_write
);

    pspf_pkg::cfg_t  cfg_reg;
    pspf_pkg::ctrl_t ctrl;
    pspf_pkg::stat_t stat;
    logic            write_enable;
    logic [31:0]     write_addr, write_data;
    logic [1:0]      nibble_select;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pspf_pkg::REG_PATTERN_BITS: cfg_reg.pattern_bits   <= cfg_wdata;
                pspf_pkg::REG_FG_PIXEL:     cfg_reg.fg_pixel       <= cfg_wdata[31:0];
                pspf_pkg::REG_BG_PIXEL:     cfg_reg.bg_pixel       <= cfg_wdata[31:0];
                pspf_pkg::REG_ORIGIN:       cfg_reg.pattern_origin <= cfg_wdata[5:0];
                pspf_pkg::REG_FILL_MODE:    cfg_reg.fill_mode      <= cfg_wdata[1:0];
                pspf_pkg::REG_FRAME_BASE:   cfg_reg.frame_base     <= cfg_wdata[31:0];
                pspf_pkg::REG_ROW_STRIDE:   cfg_reg.row_stride     <= cfg_wdata[15:0];
                pspf_pkg::REG_CLIP_WINDOW:  cfg_reg.clip_window    <= cfg_wdata;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    pspf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    pspf_dp #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .span_row      (s_tdata[15:0]),
        .span_x_start  (s_tdata[31:16]),
        .span_x_end    (s_tdata[47:32]),
        .ctrl          (ctrl),
        .stat          (stat),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .write_enable  (write_enable),
        .write_addr    (write_addr),
        .write_data    (write_data),
        .nibble_select (nibble_select),
        .last_write    (m_tlast)
    );

    // Pack the output stream
    assign m_tdata = {write_data, write_addr};
    assign m_tuser = {nibble_select, write_enable};

endmodule

### hdl/pspf_checker.sv
// ----------------------------------------------------------------------------
// Pattern span fill port checker
// Port-level checks on the span fill unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "pattern_span_fill_unit_macros.svh"

module pspf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic [2:0]  cfg_index,
    input logic [63:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled output holds
    `PSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

    // One span at a time: input closes after a transfer
    `PSF_ASSERT_NEXT(a_one_span, s_tvalid && s_tready, !s_tready, "input ready right after a span transfer")

    // Disabled writes carry zero data
    `PSF_ASSERT_NOW(a_skip_zero, m_tvalid && !m_tuser[0], m_tdata[63:32] == 32'd0, "disabled write with nonzero data")

    // Nibble writes carry four data bits only
    `PSF_ASSERT_NOW(a_nibble_data, m_tvalid && !m_tuser[2], m_tdata[63:36] == 28'd0 && m_tuser[2:1] != 2'b11, "nibble write with wide data or bad select")

endmodule

bind pattern_span_fill_unit pspf_checker u_pspf_checker (.*);
